[rtl/core/wvb_pkg.sv]
// wvb_pkg: shared types and constants for the two-view wiener bin pipeline
// no dependencies
package wvb_pkg;

	localparam int OBS_W   = 32;
	localparam int PSF_W   = 16;
	localparam int PROD_W  = OBS_W + PSF_W;
	localparam int NUM_W   = PROD_W + 2;
	localparam int MAG_W   = NUM_W - 1;
	localparam int NOISE_W = 30;
	localparam int DEN_W   = 33;
	localparam int OUT_W   = 40;
	localparam int FRAC_W  = 14;
	localparam int HI_W    = MAG_W + FRAC_W - OUT_W;
	localparam logic [NOISE_W-1:0] NOISE_RESET = 30'd536871;

	typedef struct packed {
		logic              neg;
		logic              ovf;
		logic [DEN_W-1:0]  rem;
		logic [OUT_W-1:0]  dvd;
		logic [OUT_W-1:0]  quo;
	} div_lane_t;

	typedef struct packed {
		logic [DEN_W-1:0] den;
		div_lane_t        re;
		div_lane_t        im;
	} div_item_t;

endpackage

[rtl/core/wvb_front.sv]
// wvb_front: products, sums and divider setup in three pipeline stages
// depends on wvb_pkg
module wvb_front import wvb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [NOISE_W-1:0]       noise,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [OBS_W-1:0]  obs_left_re,
	input  logic signed [OBS_W-1:0]  obs_left_im,
	input  logic signed [OBS_W-1:0]  obs_right_re,
	input  logic signed [OBS_W-1:0]  obs_right_im,
	input  logic signed [PSF_W-1:0]  psf_left_re,
	input  logic signed [PSF_W-1:0]  psf_left_im,
	input  logic signed [PSF_W-1:0]  psf_right_re,
	input  logic signed [PSF_W-1:0]  psf_right_im,
	output logic                     item_valid,
	input  logic                     item_ready,
	output div_item_t                item
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic signed [PROD_W-1:0]  pre_s1 [4];
	logic signed [PROD_W-1:0]  pim_s1 [4];
	logic signed [2*PSF_W-1:0] sq_s1 [4];
	logic signed [NUM_W-1:0]  nre_s2, nim_s2;
	logic [DEN_W-1:0]         den_s2;
	logic [DEN_W-1:0]         den_sum;
	div_item_t                item_s3;

	assign en3 = !v_s3 || item_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign item_valid = v_s3;
	assign item = item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pre_s1[0] <= psf_left_re * obs_left_re;
			pre_s1[1] <= psf_left_im * obs_left_im;
			pre_s1[2] <= psf_right_re * obs_right_re;
			pre_s1[3] <= psf_right_im * obs_right_im;
			pim_s1[0] <= psf_left_re * obs_left_im;
			pim_s1[1] <= -(psf_left_im * obs_left_re);
			pim_s1[2] <= psf_right_re * obs_right_im;
			pim_s1[3] <= -(psf_right_im * obs_right_re);
			sq_s1[0]  <= psf_left_re * psf_left_re;
			sq_s1[1]  <= psf_left_im * psf_left_im;
			sq_s1[2]  <= psf_right_re * psf_right_re;
			sq_s1[3]  <= psf_right_im * psf_right_im;
		end
	end

	always_comb begin
		den_sum = DEN_W'(sq_s1[0]) + DEN_W'(sq_s1[1]) + DEN_W'(sq_s1[2])
			+ DEN_W'(sq_s1[3]) + DEN_W'(noise);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			nre_s2 <= NUM_W'(pre_s1[0]) + NUM_W'(pre_s1[1]) + NUM_W'(pre_s1[2])
				+ NUM_W'(pre_s1[3]);
			nim_s2 <= NUM_W'(pim_s1[0]) + NUM_W'(pim_s1[1]) + NUM_W'(pim_s1[2])
				+ NUM_W'(pim_s1[3]);
			den_s2 <= (den_sum == '0) ? DEN_W'(1) : den_sum;
		end
	end

	function automatic div_lane_t lane_setup(logic signed [NUM_W-1:0] n,
		logic [DEN_W-1:0] d);
		div_lane_t l;
		logic [NUM_W-1:0] a;
		logic [MAG_W-1:0] m;
		a = n[NUM_W-1] ? (~n + NUM_W'(1)) : n;
		m = a[MAG_W-1:0];
		l.neg = n[NUM_W-1];
		l.ovf = DEN_W'(m[MAG_W-1 -: HI_W]) >= d;
		l.rem = DEN_W'(m[MAG_W-1 -: HI_W]);
		l.dvd = {m[MAG_W-HI_W-1:0], {FRAC_W{1'b0}}};
		l.quo = '0;
		return l;
	endfunction

	always_ff @(posedge clk) begin
		if (en3) begin
			item_s3.den <= den_s2;
			item_s3.re  <= lane_setup(nre_s2, den_s2);
			item_s3.im  <= lane_setup(nim_s2, den_s2);
		end
	end

endmodule

[rtl/core/wvb_divider.sv]
// wvb_divider: restoring divider, one quotient bit per pipeline stage, two lanes
// depends on wvb_pkg
module wvb_divider import wvb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output div_item_t out_item
);

	div_item_t  st_q [OUT_W];
	logic [OUT_W-1:0] v_q;
	logic [OUT_W:0]   en;

	function automatic div_lane_t lane_step(div_lane_t l, logic [DEN_W-1:0] d);
		div_lane_t r;
		logic [DEN_W:0] rr;
		r = l;
		rr = {l.rem, l.dvd[OUT_W-1]};
		r.dvd = {l.dvd[OUT_W-2:0], 1'b0};
		if (rr >= {1'b0, d}) begin
			r.rem = DEN_W'(rr - {1'b0, d});
			r.quo = {l.quo[OUT_W-2:0], 1'b1};
		end else begin
			r.rem = rr[DEN_W-1:0];
			r.quo = {l.quo[OUT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	assign en[OUT_W] = out_ready;
	assign in_ready = en[0];
	assign out_valid = v_q[OUT_W-1];
	assign out_item = st_q[OUT_W-1];

	for (genvar i = 0; i < OUT_W; i++) begin : g_stage
		div_item_t src;
		logic      src_v;
		assign en[i] = !v_q[i] || en[i+1];
		if (i == 0) begin : g_first
			assign src = in_item;
			assign src_v = in_valid;
		end else begin : g_next
			assign src = st_q[i-1];
			assign src_v = v_q[i-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i] <= 1'b0;
			else if (en[i]) v_q[i] <= src_v;
		end
		always_ff @(posedge clk) begin
			if (en[i]) begin
				st_q[i].den <= src.den;
				st_q[i].re  <= lane_step(src.re, src.den);
				st_q[i].im  <= lane_step(src.im, src.den);
			end
		end
	end

endmodule

[rtl/core/dual_view_wiener_bin_top.sv]
// dual_view_wiener_bin_top: two-view wiener deconvolution of one bin, apb noise register
// depends on wvb_pkg, wvb_front, wvb_divider
//
// one beat in carries both observed bins and both kernel bins; one beat out
// carries latent_re, latent_im and saturated. both channels are valid/ready.
// the noise_floor register sits at byte address 0 of the apb port.
// a beat passes through three stages of multiply, sum and divider setup,
// forty stages of the bit-per-stage restoring divider, and one saturating
// output register on its way from input beat to output beat.
// throughput is one beat per cycle unless stalled; every stage holds its own valid bit.
// when the receiver stalls, stages fill up from the output back, and
// in_ready falls only once every stage is full. nothing is dropped.
// reset clears all valid bits and loads noise_floor with its default.
// write noise_floor only while no beat is in flight.
module dual_view_wiener_bin_top import wvb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [OBS_W-1:0]  obs_left_re,
	input  logic signed [OBS_W-1:0]  obs_left_im,
	input  logic signed [OBS_W-1:0]  obs_right_re,
	input  logic signed [OBS_W-1:0]  obs_right_im,
	input  logic signed [PSF_W-1:0]  psf_left_re,
	input  logic signed [PSF_W-1:0]  psf_left_im,
	input  logic signed [PSF_W-1:0]  psf_right_re,
	input  logic signed [PSF_W-1:0]  psf_right_im,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [OUT_W-1:0]  latent_re,
	output logic signed [OUT_W-1:0]  latent_im,
	output logic                     saturated
);

	localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	logic [NOISE_W-1:0] noise_q;
	logic               f_valid, f_ready, d_valid, d_ready;
	div_item_t          f_item, d_item;
	logic               ov_q;
	logic [OUT_W-1:0]   lre_q, lim_q;
	logic               sat_q;
	logic [OUT_W-1:0]   vre, vim;
	logic               cre, cim;

	assign pready = 1'b1;
	assign prdata = {{(32-NOISE_W){1'b0}}, noise_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) noise_q <= NOISE_RESET;
		else if (psel && penable && pwrite && !paddr[2]) noise_q <= pwdata[NOISE_W-1:0];
	end

	wvb_front u_front (
		.clk, .arst_n, .noise(noise_q),
		.in_valid, .in_ready,
		.obs_left_re, .obs_left_im, .obs_right_re, .obs_right_im,
		.psf_left_re, .psf_left_im, .psf_right_re, .psf_right_im,
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	wvb_divider u_div (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(d_valid), .out_ready(d_ready), .out_item(d_item)
	);

	function automatic logic [OUT_W:0] lane_sat(div_lane_t l);
		logic clip;
		logic [OUT_W-1:0] v;
		if (l.neg) begin
			clip = l.ovf || (l.quo > NEG_MIN);
			v = clip ? NEG_MIN : (~l.quo + OUT_W'(1));
		end else begin
			clip = l.ovf || l.quo[OUT_W-1];
			v = clip ? POS_MAX : l.quo;
		end
		return {clip, v};
	endfunction

	assign {cre, vre} = lane_sat(d_item.re);
	assign {cim, vim} = lane_sat(d_item.im);
	assign d_ready = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (d_ready) ov_q <= d_valid;
	end

	always_ff @(posedge clk) begin
		if (d_ready) begin
			lre_q <= vre;
			lim_q <= vim;
			sat_q <= cre || cim;
		end
	end

	assign out_valid = ov_q;
	assign latent_re = lre_q;
	assign latent_im = lim_q;
	assign saturated = sat_q;

endmodule
